@@ sv/frcb_pkg.sv @@
// ----------------------------------------------------------------------------
// frcb_pkg
// Shared types and constants for the failure-rate circuit breaker.
// ----------------------------------------------------------------------------
package frcb_pkg;

  localparam int unsigned RingDepth   = 128;
  localparam int unsigned CounterBits = 32;
  localparam int unsigned FillW       = $clog2(RingDepth + 1);
  localparam int unsigned PosW        = $clog2(RingDepth);

  localparam logic [63:0] NsPerMs    = 64'd1000000;
  localparam logic [63:0] LookbackNs = 64'd60000000000;

  localparam logic [7:0]  FailThrRst    = 8'd5;
  localparam logic [7:0]  SuccThrRst    = 8'd3;
  localparam logic [31:0] OpenTimeoutMs = 32'd30000;
  localparam logic [7:0]  WindowRst     = 8'd100;
  localparam logic [7:0]  ProbeLimRst   = 8'd3;

  typedef enum logic [2:0] {
    CMD_QUERY   = 3'd0,
    CMD_SUCCESS = 3'd1,
    CMD_FAILURE = 3'd2,
    CMD_FOPEN   = 3'd3,
    CMD_FCLOSE  = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    REG_FAIL_THR  = 3'd0,
    REG_SUCC_THR  = 3'd1,
    REG_TIMEOUT   = 3'd2,
    REG_WINDOW    = 3'd3,
    REG_PROBE_LIM = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BRK_CLOSED = 2'd0,
    BRK_OPEN   = 2'd1,
    BRK_HALF   = 2'd2
  } brk_e;

  typedef struct packed {
    logic [63:0] stamp;
    logic        fail;
  } entry_t;

  typedef struct packed {
    logic   en;
    logic   load_new;
    entry_t new_entry;
  } chain_ctrl_t;

endpackage

@@ sv/frcb_cell.sv @@
// ----------------------------------------------------------------------------
// frcb_cell
// One outcome slot of the history chain; takes its neighbor's entry on enable.
// ----------------------------------------------------------------------------
module frcb_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  frcb_pkg::entry_t d_i,
  output frcb_pkg::entry_t q_o
);
  import frcb_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

@@ sv/frcb_chain.sv @@
// ----------------------------------------------------------------------------
// frcb_chain
// Row of history cells. Newest outcome enters cell 0; with no new entry the
// row rotates, the last cell feeding cell 0.
// ----------------------------------------------------------------------------
module frcb_chain (
  input  logic                  clk_i,
  input  frcb_pkg::chain_ctrl_t ctrl_i,
  output frcb_pkg::entry_t      last_o
);
  import frcb_pkg::*;

  entry_t taps [RingDepth];
  entry_t head_in;

  assign head_in = ctrl_i.load_new ? ctrl_i.new_entry : taps[RingDepth-1];

  for (genvar g = 0; g < RingDepth; g++) begin : g_cell
    if (g == 0) begin : g_first
      frcb_cell u_cell (.clk_i(clk_i), .en_i(ctrl_i.en), .d_i(head_in), .q_o(taps[g]));
    end else begin : g_rest
      frcb_cell u_cell (.clk_i(clk_i), .en_i(ctrl_i.en), .d_i(taps[g-1]), .q_o(taps[g]));
    end
  end

  assign last_o = taps[RingDepth-1];

endmodule

@@ sv/failure_rate_circuit_breaker.sv @@
// ----------------------------------------------------------------------------
// failure_rate_circuit_breaker
// Closed/open/half-open breaker with a sliding window of recent outcomes.
// ----------------------------------------------------------------------------
// Usage:
//   Event requests (command_i, timestamp_i) come in on in_valid_i/in_ready_o;
//   one result per request leaves on out_valid_o/out_ready_i from an output
//   register. Registers are written on cfg_valid_i/cfg_ready_o (always ready)
//   with cfg_index_i and cfg_data_i; the user must write them only while the
//   block is idle, which the block does not enforce. A failure while closed
//   rotates the history chain once in FSM_SCAN, counting recent failures at
//   the last cell, then decides in FSM_FIN; other requests load their result
//   in the cycle they are taken. One request is in work at a time; a new one
//   is taken once the block is idle and the output register is free or
//   drains. A stalled receiver holds the result and blocks new requests.
//   Reset: breaker closed, counters and history empty, registers at defaults.
// ----------------------------------------------------------------------------
module failure_rate_circuit_breaker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        allowed_o,
  output logic [1:0]  breaker_state_o,
  output logic [31:0] total_calls_o,
  output logic [31:0] success_calls_o,
  output logic [31:0] failed_calls_o,
  output logic [31:0] rejected_calls_o,
  output logic [31:0] state_changes_o,
  output logic [63:0] last_failure_time_o
);
  import frcb_pkg::*;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_SCAN = 3'b010,
    FSM_FIN  = 3'b100
  } fsm_e;

  typedef logic [CounterBits-1:0] ctr_t;

  function automatic ctr_t sat_inc(ctr_t v);
    return (v == '1) ? v : v + ctr_t'(1);
  endfunction

  function automatic logic [31:0] clip32(ctr_t v);
    return (64'(v) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
  endfunction

  // configuration
  logic [7:0]  fail_thr_q, succ_thr_q, window_q, probe_lim_q;
  logic [63:0] timeout_ns_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_thr_q   <= FailThrRst;
      succ_thr_q   <= SuccThrRst;
      timeout_ns_q <= 64'(OpenTimeoutMs) * NsPerMs;
      window_q     <= WindowRst;
      probe_lim_q  <= ProbeLimRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FAIL_THR:  fail_thr_q   <= cfg_data_i[7:0];
        REG_SUCC_THR:  succ_thr_q   <= cfg_data_i[7:0];
        REG_TIMEOUT:   timeout_ns_q <= 64'(cfg_data_i) * NsPerMs;
        REG_WINDOW:    window_q     <= cfg_data_i[7:0];
        REG_PROBE_LIM: probe_lim_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [15:0]      cap16;
  logic [FillW-1:0] cap;

  always_comb begin
    if (window_q == 8'd0) begin
      cap16 = 16'd1;
    end else if (16'(window_q) > 16'(RingDepth)) begin
      cap16 = 16'(RingDepth);
    end else begin
      cap16 = 16'(window_q);
    end
    cap = FillW'(cap16);
  end

  // state
  fsm_e             fsm_q, fsm_d;
  brk_e             brk_q, brk_d;
  logic [63:0]      opened_q, opened_d;
  logic [7:0]       psucc_q, psucc_d, pfail_q, pfail_d;
  logic [FillW-1:0] fill_q, fill_d, cnt_q, cnt_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [63:0]      since_q, since_d, now_q, now_d;
  ctr_t             tot_q, tot_d, suc_q, suc_d, fal_q, fal_d, rej_q, rej_d, chg_q, chg_d;
  logic [63:0]      lastf_q, lastf_d;
  logic             ov_q, ov_d, allowed_d, load_out, accept, out_free;
  chain_ctrl_t      chain_ctrl;
  entry_t           last_entry;

  frcb_chain u_chain (.clk_i(clk_i), .ctrl_i(chain_ctrl), .last_o(last_entry));

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (fsm_q == FSM_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    fsm_d = fsm_q; brk_d = brk_q; opened_d = opened_q;
    psucc_d = psucc_q; pfail_d = pfail_q; fill_d = fill_q;
    cnt_d = cnt_q; pos_d = pos_q; since_d = since_q; now_d = now_q;
    tot_d = tot_q; suc_d = suc_q; fal_d = fal_q; rej_d = rej_q; chg_d = chg_q;
    lastf_d = lastf_q;
    allowed_d = 1'b0;
    load_out = 1'b0;
    chain_ctrl.en = 1'b0;
    chain_ctrl.load_new = 1'b0;
    chain_ctrl.new_entry.stamp = timestamp_i;
    chain_ctrl.new_entry.fail = (cmd_e'(command_i) == CMD_FAILURE);

    unique case (fsm_q)
      FSM_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (cmd_e'(command_i))
            CMD_QUERY: begin
              unique case (brk_q)
                BRK_CLOSED: allowed_d = 1'b1;
                BRK_OPEN: begin
                  if (timestamp_i - opened_q >= timeout_ns_q) begin
                    brk_d = BRK_HALF; chg_d = sat_inc(chg_q);
                    psucc_d = '0; pfail_d = '0; allowed_d = 1'b1;
                  end else begin
                    rej_d = sat_inc(rej_q);
                  end
                end
                default: begin
                  if (9'(psucc_q) + 9'(pfail_q) < 9'(probe_lim_q)) begin
                    allowed_d = 1'b1;
                  end else begin
                    rej_d = sat_inc(rej_q);
                  end
                end
              endcase
            end
            CMD_SUCCESS, CMD_FAILURE: begin
              chain_ctrl.en = 1'b1;
              chain_ctrl.load_new = 1'b1;
              if (fill_q < cap) fill_d = fill_q + FillW'(1);
              tot_d = sat_inc(tot_q);
              if (cmd_e'(command_i) == CMD_SUCCESS) begin
                suc_d = sat_inc(suc_q);
                if (brk_q == BRK_HALF) begin
                  psucc_d = (psucc_q == 8'hFF) ? psucc_q : psucc_q + 8'd1;
                  if (psucc_d >= succ_thr_q) begin
                    brk_d = BRK_CLOSED; chg_d = sat_inc(chg_q);
                  end
                end
              end else begin
                fal_d = sat_inc(fal_q);
                lastf_d = timestamp_i;
                if (brk_q == BRK_HALF) begin
                  pfail_d = (pfail_q == 8'hFF) ? pfail_q : pfail_q + 8'd1;
                  if (pfail_d >= fail_thr_q) begin
                    brk_d = BRK_OPEN; chg_d = sat_inc(chg_q); opened_d = timestamp_i;
                  end
                end else if (brk_q == BRK_CLOSED) begin
                  load_out = 1'b0;
                  since_d = (timestamp_i >= LookbackNs) ? timestamp_i - LookbackNs : '0;
                  now_d = timestamp_i;
                  cnt_d = '0;
                  pos_d = PosW'(RingDepth - 1);
                  fsm_d = FSM_SCAN;
                end
              end
            end
            CMD_FOPEN: begin
              brk_d = BRK_OPEN; chg_d = sat_inc(chg_q); opened_d = timestamp_i;
            end
            CMD_FCLOSE: begin
              brk_d = BRK_CLOSED; chg_d = sat_inc(chg_q);
            end
            CMD_CLEAR: begin
              tot_d = '0; suc_d = '0; fal_d = '0; rej_d = '0; chg_d = '0; lastf_d = '0;
            end
            default: ;
          endcase
        end
      end
      FSM_SCAN: begin
        chain_ctrl.en = 1'b1;
        if ((FillW'(pos_q) < fill_q) && last_entry.fail && (last_entry.stamp >= since_q)) begin
          cnt_d = cnt_q + FillW'(1);
        end
        if (pos_q == '0) begin
          fsm_d = FSM_FIN;
        end else begin
          pos_d = pos_q - PosW'(1);
        end
      end
      FSM_FIN: begin
        if (out_free) begin
          if (32'(cnt_q) >= 32'(fail_thr_q)) begin
            brk_d = BRK_OPEN; chg_d = sat_inc(chg_q); opened_d = now_q;
          end
          load_out = 1'b1;
          fsm_d = FSM_IDLE;
        end
      end
      default: fsm_d = FSM_IDLE;
    endcase

    if (cfg_we && (cfg_reg_e'(cfg_index_i) == REG_WINDOW)) fill_d = '0;

    ov_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= FSM_IDLE; brk_q <= BRK_CLOSED; opened_q <= '0;
      psucc_q <= '0; pfail_q <= '0; fill_q <= '0; cnt_q <= '0; pos_q <= '0;
      tot_q <= '0; suc_q <= '0; fal_q <= '0; rej_q <= '0; chg_q <= '0;
      lastf_q <= '0; ov_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d; brk_q <= brk_d; opened_q <= opened_d;
      psucc_q <= psucc_d; pfail_q <= pfail_d; fill_q <= fill_d; cnt_q <= cnt_d;
      pos_q <= pos_d;
      tot_q <= tot_d; suc_q <= suc_d; fal_q <= fal_d; rej_q <= rej_d; chg_q <= chg_d;
      lastf_q <= lastf_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    since_q <= since_d;
    now_q   <= now_d;
    if (load_out) begin
      allowed_o           <= allowed_d;
      breaker_state_o     <= brk_d;
      total_calls_o       <= clip32(tot_d);
      success_calls_o     <= clip32(suc_d);
      failed_calls_o      <= clip32(fal_d);
      rejected_calls_o    <= clip32(rej_d);
      state_changes_o     <= clip32(chg_d);
      last_failure_time_o <= lastf_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Failure-rate circuit breaker testbench: directed breaker scenarios, then
// random event sequences under varying idle and stall pressure. Each result
// is checked against a breaker model kept alongside the stimulus.
// ----------------------------------------------------------------------------
module tb;
  import frcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SecNs = 64'd1000000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [63:0] timestamp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        allowed_o;
  logic [1:0]  breaker_state_o;
  logic [31:0] total_calls_o, success_calls_o, failed_calls_o;
  logic [31:0] rejected_calls_o, state_changes_o;
  logic [63:0] last_failure_time_o;

  failure_rate_circuit_breaker uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic        allowed;
    logic [1:0]  state;
    logic [31:0] total, succ, fail, rej, chg;
    logic [63:0] last_fail;
  } verdict_t;

  verdict_t verdicts_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;

  // breaker model state
  logic [7:0]  m_fail_thr, m_succ_thr, m_win, m_probe_lim;
  logic [31:0] m_timeout;
  brk_e        m_state;
  logic [63:0] m_opened;
  logic [7:0]  m_psucc, m_pfail;
  logic [63:0] m_times[RingDepth];
  logic        m_fails[RingDepth];
  int unsigned m_head, m_tail, m_fill;
  logic [31:0] m_total, m_succ, m_failc, m_rej, m_chg;
  logic [63:0] m_last_fail;
  logic [63:0] clock_ns;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic int unsigned win_cap();
    if (m_win == 0) return 1;
    if (m_win > RingDepth) return RingDepth;
    return m_win;
  endfunction

  function automatic void move_to(brk_e s, logic [63:0] now);
    m_state = s;
    m_chg = sat_inc(m_chg);
    if (s == BRK_OPEN) m_opened = now;
    else if (s == BRK_HALF) begin
      m_psucc = 0;
      m_pfail = 0;
    end
  endfunction

  function automatic void record_outcome(logic [63:0] t, logic failed);
    int unsigned c;
    c = win_cap();
    if (m_tail >= c) m_tail = 0;
    if (m_head >= c) m_head = 0;
    m_times[m_tail] = t;
    m_fails[m_tail] = failed;
    m_tail = (m_tail + 1) % c;
    if (m_fill < c) m_fill++;
    else m_head = (m_head + 1) % c;
  endfunction

  function automatic int unsigned recent_failures(logic [63:0] since);
    int unsigned c, idx, n;
    c = win_cap();
    idx = m_head % c;
    n = 0;
    for (int unsigned i = 0; i < m_fill && i < c; i++) begin
      if (m_times[idx] >= since && m_fails[idx]) n++;
      idx = (idx + 1) % c;
    end
    return n;
  endfunction

  function automatic void breaker_reset();
    m_fail_thr = FailThrRst;
    m_succ_thr = SuccThrRst;
    m_timeout = OpenTimeoutMs;
    m_win = WindowRst;
    m_probe_lim = ProbeLimRst;
    m_state = BRK_CLOSED;
    m_opened = 0;
    m_psucc = 0;
    m_pfail = 0;
    m_head = 0;
    m_tail = 0;
    m_fill = 0;
    {m_total, m_succ, m_failc, m_rej, m_chg} = '0;
    m_last_fail = 0;
  endfunction

  function automatic verdict_t breaker_event(logic [2:0] cmd, logic [63:0] now);
    verdict_t v;
    logic [63:0] since;
    v.allowed = 1'b0;
    case (cmd)
      CMD_QUERY: begin
        if (m_state == BRK_CLOSED) v.allowed = 1'b1;
        else if (m_state == BRK_OPEN) begin
          if (now - m_opened >= 64'(m_timeout) * NsPerMs) begin
            move_to(BRK_HALF, now);
            v.allowed = 1'b1;
          end else m_rej = sat_inc(m_rej);
        end else begin
          if (9'(m_psucc) + 9'(m_pfail) < 9'(m_probe_lim)) v.allowed = 1'b1;
          else m_rej = sat_inc(m_rej);
        end
      end
      CMD_SUCCESS: begin
        record_outcome(now, 1'b0);
        m_total = sat_inc(m_total);
        m_succ = sat_inc(m_succ);
        if (m_state == BRK_HALF) begin
          if (m_psucc != 8'hff) m_psucc++;
          if (m_psucc >= m_succ_thr) move_to(BRK_CLOSED, now);
        end
      end
      CMD_FAILURE: begin
        record_outcome(now, 1'b1);
        m_total = sat_inc(m_total);
        m_failc = sat_inc(m_failc);
        m_last_fail = now;
        if (m_state == BRK_HALF) begin
          if (m_pfail != 8'hff) m_pfail++;
          if (m_pfail >= m_fail_thr) move_to(BRK_OPEN, now);
        end else if (m_state == BRK_CLOSED) begin
          since = (now >= LookbackNs) ? now - LookbackNs : 64'd0;
          if (recent_failures(since) >= m_fail_thr) move_to(BRK_OPEN, now);
        end
      end
      CMD_FOPEN: move_to(BRK_OPEN, now);
      CMD_FCLOSE: move_to(BRK_CLOSED, now);
      CMD_CLEAR: begin
        {m_total, m_succ, m_failc, m_rej, m_chg} = '0;
        m_last_fail = 0;
      end
      default: ;
    endcase
    v.state = m_state;
    v.total = m_total;
    v.succ = m_succ;
    v.fail = m_failc;
    v.rej = m_rej;
    v.chg = m_chg;
    v.last_fail = m_last_fail;
    return v;
  endfunction

  // valid stays high between back-to-back requests; idle cycles drop it
  task automatic send_event(logic [2:0] cmd, logic [63:0] now);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    verdicts_q.push_back(breaker_event(cmd, now));
    in_valid_i <= 1'b1;
    command_i <= cmd;
    timestamp_i <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // advances the time stamp by the given step, then sends the event
  task automatic send_at(logic [2:0] cmd, logic [63:0] step);
    clock_ns = clock_ns + step;
    send_event(cmd, clock_ns);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    in_valid_i <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk_i);
    repeat (RingDepth + 8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FAIL_THR:  m_fail_thr = val[7:0];
      REG_SUCC_THR:  m_succ_thr = val[7:0];
      REG_TIMEOUT:   m_timeout = val;
      REG_WINDOW: begin
        m_win = val[7:0];
        m_head = 0;
        m_tail = 0;
        m_fill = 0;
      end
      REG_PROBE_LIM: m_probe_lim = val[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {allowed_o, breaker_state_o, total_calls_o, success_calls_o,
               failed_calls_o, rejected_calls_o, state_changes_o, last_failure_time_o};
        if (verdicts_q.size() == 0) begin
          $display("%t unexpected result %h", $realtime, got);
          errors++;
        end else begin
          want = verdicts_q.pop_front();
          if (got.allowed !== want.allowed)
            $display("%t allowed exp %0d got %0d", $realtime, want.allowed, got.allowed);
          if (got.state !== want.state)
            $display("%t state exp %0d got %0d", $realtime, want.state, got.state);
          if (got.total !== want.total)
            $display("%t total exp %0d got %0d", $realtime, want.total, got.total);
          if (got.succ !== want.succ)
            $display("%t success exp %0d got %0d", $realtime, want.succ, got.succ);
          if (got.fail !== want.fail)
            $display("%t failed exp %0d got %0d", $realtime, want.fail, got.fail);
          if (got.rej !== want.rej)
            $display("%t rejected exp %0d got %0d", $realtime, want.rej, got.rej);
          if (got.chg !== want.chg)
            $display("%t changes exp %0d got %0d", $realtime, want.chg, got.chg);
          if (got.last_fail !== want.last_fail)
            $display("%t last failure exp %h got %h", $realtime, want.last_fail,
                     got.last_fail);
          if (got !== want) errors++;
        end
      end
      out_ready_i <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  task automatic test_directed();
    // query, success, clear, unused codes, extreme timestamps
    send_event(CMD_QUERY, 64'd0);
    send_event(CMD_SUCCESS, 64'hffff_ffff_ffff_ffff);
    send_event(3'd6, 64'h5555_5555_5555_5555);
    send_event(3'd7, 64'haaaa_aaaa_aaaa_aaaa);
    send_event(CMD_CLEAR, 64'd0);
    // early look-back: failures at small times open the breaker
    for (int i = 0; i < 5; i++) send_event(CMD_FAILURE, 64'(i) * SecNs);
    send_event(CMD_QUERY, 64'd10 * SecNs);
    // time running backwards reads as a long open time
    send_event(CMD_QUERY, 64'd1);
    send_event(CMD_QUERY, 64'd2);
    send_event(CMD_SUCCESS, 64'd3);
    send_event(CMD_QUERY, 64'd4);
    send_event(CMD_QUERY, 64'd5);
    send_event(CMD_QUERY, 64'd6);
    send_event(CMD_SUCCESS, 64'd7);
    send_event(CMD_SUCCESS, 64'd8);
    // force in same state
    send_event(CMD_FOPEN, 64'd9);
    send_event(CMD_FOPEN, 64'd10);
    send_event(CMD_FCLOSE, 64'd11);
    send_event(CMD_FCLOSE, 64'd12);
    clock_ns = 64'd100 * SecNs;
  endtask

  task automatic test_zero_thresholds();
    write_reg(REG_FAIL_THR, 32'd0);
    write_reg(REG_SUCC_THR, 32'd0);
    write_reg(REG_PROBE_LIM, 32'd0);
    write_reg(REG_TIMEOUT, 32'd1);
    write_reg(REG_WINDOW, 32'd0);
    send_at(CMD_FAILURE, 64'd5);
    send_at(CMD_QUERY, 64'd2000000);
    send_at(CMD_QUERY, 64'd1);
    send_at(CMD_FAILURE, 64'd1);
    send_at(CMD_QUERY, 64'd2000000);
    send_at(CMD_SUCCESS, 64'd1);
    write_reg(REG_WINDOW, 32'd255);
    write_reg(REG_FAIL_THR, 32'd255);
    write_reg(REG_SUCC_THR, 32'd255);
    write_reg(REG_PROBE_LIM, 32'd255);
    write_reg(REG_TIMEOUT, 32'hffff_ffff);
    for (int i = 0; i < 6; i++) send_at(CMD_FAILURE, 64'd1000);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    logic [2:0] cmd;
    int r;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      cmd = (r < 35) ? CMD_QUERY : (r < 60) ? CMD_SUCCESS : (r < 88) ? CMD_FAILURE :
            (r < 92) ? CMD_FOPEN : (r < 95) ? CMD_FCLOSE : (r < 98) ? CMD_CLEAR :
            3'($urandom_range(7));
      r = $urandom_range(99);
      if (r < 2) clock_ns = {$urandom, $urandom};
      else if (r < 10) clock_ns = clock_ns + 64'($urandom_range(90)) * SecNs;
      else clock_ns = clock_ns + 64'($urandom_range(3000)) * 64'd1000000;
      send_event(cmd, clock_ns);
    end
  endtask

  task automatic test_random();
    write_reg(REG_FAIL_THR, 32'd3);
    write_reg(REG_SUCC_THR, 32'd2);
    write_reg(REG_TIMEOUT, 32'd2000);
    write_reg(REG_WINDOW, 32'd8);
    write_reg(REG_PROBE_LIM, 32'd2);
    random_phase(450, 0, 0);
    write_reg(REG_WINDOW, 32'd128);
    write_reg(REG_FAIL_THR, 32'd1);
    random_phase(450, 83, 0);
    write_reg(REG_WINDOW, 32'd1);
    write_reg(REG_FAIL_THR, 32'd2);
    write_reg(REG_TIMEOUT, 32'd500);
    random_phase(450, 0, 83);
    write_reg(REG_WINDOW, 32'd20);
    write_reg(REG_PROBE_LIM, 32'd4);
    random_phase(450, 25, 25);
    send_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    breaker_reset();
    clock_ns = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_thresholds();
    test_random();
    in_valid_i <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk_i);
    repeat (RingDepth + 8) @(posedge clk_i);
    if (errors == 0) $display("PASS failure_rate_circuit_breaker");
    else $display("FAIL failure_rate_circuit_breaker");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL failure_rate_circuit_breaker");
    $finish;
  end
endmodule
